// ===== rtl/mlq_pkg.sv =====
// Shared types and codes for the multilevel ready queue scheduler.
// Holds the request and response payload structs, operation and status codes and the
// sequencer state type. Depends on nothing.
package mlq_pkg;

   typedef struct packed {
      logic [1:0] operation;
      logic [5:0] task_index;
      logic [3:0] priority_req;
      logic       outgoing_ended;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [5:0] picked_task;
      logic [6:0] ready_total;
   } rsp_type;

   localparam logic [1:0] OP_ENQUEUE  = 2'd0;
   localparam logic [1:0] OP_SCHEDULE = 2'd1;
   localparam logic [1:0] OP_REMOVE   = 2'd2;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_BAD_PRIO  = 2'd2;
   localparam logic [1:0] ST_QUEUED    = 2'd3;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOK,
      S_ENQ,
      S_UNLINK_A,
      S_UNLINK_B,
      S_OUT_RD,
      S_OUT_CHK,
      S_DONE
   } seq_state_type;

endpackage

// ===== rtl/mlq_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the task link and queue-membership storage. Depends on nothing.
module mlq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/multilevel_ready_queue_scheduler_core.sv =====
// Top level of the multilevel ready queue scheduler with per-level quota.
// Depends on mlq_pkg for payload types and codes and on mlq_ram for link storage.
//
//   channel   direction   handshake                payload
//   req       in          req_valid / req_stall    mlq_pkg::req_type
//   rsp       out         rsp_valid / rsp_stall    mlq_pkg::rsp_type
//
// Requests are taken one at a time; a schedule may also append the outgoing task.
// After reset a clearing pass marks every task as not queued;
// no request is taken during it.
// A finished response waits in the output register; the next request is taken
// meanwhile, and its own response waits until that register frees.
module multilevel_ready_queue_scheduler_core #(
   parameter int LEVELS = 5,
   parameter int TASKS  = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  mlq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output mlq_pkg::rsp_type rsp_data
);
   import mlq_pkg::*;

   localparam int TW   = $clog2(TASKS);
   localparam int LW   = $clog2(LEVELS);
   localparam int CW   = $clog2(TASKS + 1);
   localparam int AUXW = 1 + LW + TW;

   seq_state_type state_ff, state_in;
   req_type       cmd_ff, cmd_in;
   logic [TW-1:0] tgt_ff, tgt_in;
   logic [TW-1:0] out_ff, out_in;
   logic [TW-1:0] running_ff, running_in;
   logic [TW-1:0] clr_ff, clr_in;
   logic [1:0]    status_ff, status_in;
   logic [5:0]    picked_ff, picked_in;
   logic [CW-1:0] total_ff, total_in;
   logic [TW-1:0] head_ff [LEVELS];
   logic [TW-1:0] head_in [LEVELS];
   logic [TW-1:0] tail_ff [LEVELS];
   logic [TW-1:0] tail_in [LEVELS];
   logic [CW-1:0] count_ff [LEVELS];
   logic [CW-1:0] count_in [LEVELS];
   logic [CW-1:0] quota_ff [LEVELS];
   logic [CW-1:0] quota_in [LEVELS];
   logic [CW-1:0] quota_sched [LEVELS];
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;

   logic            aux_we, aux_re, nxt_we, nxt_re;
   logic [TW-1:0]   aux_waddr, aux_raddr, nxt_waddr, nxt_raddr;
   logic [AUXW-1:0] aux_wdata, aux_rdata;
   logic [TW-1:0]   nxt_wdata, nxt_rdata;

   logic          accept, rsp_free, t_ok, pr_ok;
   logic [TW-1:0] t_idx;
   logic [LW-1:0] pr_idx, rd_lv, sel;
   logic          rd_q, found1, hit;
   logic [TW-1:0] rd_pv;
   logic [LEVELS-1:0] gt, nz;
   logic          push_en;
   logic [TW-1:0] push_task;

   assign accept   = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign t_ok     = (32'(cmd_ff.task_index) < TASKS);
   assign pr_ok    = (32'(cmd_ff.priority_req) < LEVELS);
   assign t_idx    = TW'(cmd_ff.task_index);
   assign pr_idx   = LW'(cmd_ff.priority_req);
   assign rd_q     = aux_rdata[AUXW-1];
   assign rd_lv    = aux_rdata[AUXW-2:TW];
   assign rd_pv    = aux_rdata[TW-1:0];

   mlq_ram #(.WIDTH(AUXW), .DEPTH(TASKS)) u_aux_ram (
      .clock (clock),
      .we    (aux_we),
      .waddr (aux_waddr),
      .wdata (aux_wdata),
      .re    (aux_re),
      .raddr (aux_raddr),
      .rdata (aux_rdata)
   );

   mlq_ram #(.WIDTH(TW), .DEPTH(TASKS)) u_nxt_ram (
      .clock (clock),
      .we    (nxt_we),
      .waddr (nxt_waddr),
      .wdata (nxt_wdata),
      .re    (nxt_re),
      .raddr (nxt_raddr),
      .rdata (nxt_rdata)
   );

   always_comb begin : level_scan
      for (int lv = 0; lv < LEVELS; lv++) begin
         gt[lv] = (count_ff[lv] > quota_ff[lv]);
         nz[lv] = (count_ff[lv] != '0);
      end
      found1 = |gt;
      sel = '0;
      hit = 1'b0;
      for (int lv = 0; lv < LEVELS; lv++) begin
         if (!hit && (found1 ? gt[lv] : nz[lv])) begin
            sel = LW'(lv);
            hit = 1'b1;
         end
      end
      for (int lv = 0; lv < LEVELS; lv++) begin
         if (LW'(lv) < sel) begin
            quota_sched[lv] = '0;
         end else if (LW'(lv) == sel) begin
            quota_sched[lv] = found1 ? quota_ff[lv] + 1'b1 : CW'(1);
         end else begin
            quota_sched[lv] = found1 ? quota_ff[lv] : '0;
         end
      end
   end

   always_comb begin : next_state
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_ff == TW'(TASKS - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) state_in = S_LOOK;
         end
         S_LOOK: begin
            case (cmd_ff.operation)
               OP_ENQUEUE:  state_in = (t_ok && pr_ok) ? S_ENQ : S_DONE;
               OP_REMOVE:   state_in = t_ok ? S_UNLINK_A : S_DONE;
               OP_SCHEDULE: state_in = (total_ff != '0) ? S_UNLINK_A : S_DONE;
               default:     state_in = S_DONE;
            endcase
         end
         S_ENQ:      state_in = S_DONE;
         S_UNLINK_A: state_in = rd_q ? S_UNLINK_B : S_DONE;
         S_UNLINK_B: begin
            if (cmd_ff.operation == OP_SCHEDULE && !cmd_ff.outgoing_ended && pr_ok) begin
               state_in = S_OUT_RD;
            end else begin
               state_in = S_DONE;
            end
         end
         S_OUT_RD:  state_in = S_OUT_CHK;
         S_OUT_CHK: state_in = S_DONE;
         S_DONE: begin
            if (rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin : datapath
      cmd_in       = cmd_ff;
      tgt_in       = tgt_ff;
      out_in       = out_ff;
      running_in   = running_ff;
      clr_in       = clr_ff;
      status_in    = status_ff;
      picked_in    = picked_ff;
      total_in     = total_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      quota_in     = quota_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      aux_we       = 1'b0;
      aux_waddr    = tgt_ff;
      aux_wdata    = '0;
      aux_re       = 1'b0;
      aux_raddr    = t_idx;
      nxt_we       = 1'b0;
      nxt_waddr    = rd_pv;
      nxt_wdata    = nxt_rdata;
      nxt_re       = 1'b0;
      nxt_raddr    = t_idx;
      push_en      = 1'b0;
      push_task    = tgt_ff;

      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;

      case (state_ff)
         S_CLEAR: begin
            aux_we    = 1'b1;
            aux_waddr = clr_ff;
            aux_wdata = '0;
            clr_in    = clr_ff + 1'b1;
         end
         S_IDLE: begin
            if (accept) begin
               cmd_in = req_data;
               out_in = running_ff;
            end
         end
         S_LOOK: begin
            status_in = ST_NOT_FOUND;
            picked_in = '0;
            case (cmd_ff.operation)
               OP_ENQUEUE: begin
                  if (t_ok && !pr_ok) status_in = ST_BAD_PRIO;
                  aux_re = 1'b1;
                  tgt_in = t_idx;
               end
               OP_REMOVE: begin
                  aux_re = 1'b1;
                  nxt_re = 1'b1;
                  tgt_in = t_idx;
               end
               OP_SCHEDULE: begin
                  if (total_ff != '0) begin
                     quota_in  = quota_sched;
                     tgt_in    = head_ff[sel];
                     aux_re    = 1'b1;
                     aux_raddr = head_ff[sel];
                     nxt_re    = 1'b1;
                     nxt_raddr = head_ff[sel];
                  end
               end
               default: begin
                  status_in = ST_NOT_FOUND;
               end
            endcase
         end
         S_ENQ: begin
            if (rd_q) begin
               status_in = ST_QUEUED;
            end else begin
               status_in = ST_OK;
               push_en   = 1'b1;
               push_task = tgt_ff;
            end
         end
         S_UNLINK_A: begin
            if (rd_q) begin
               if (head_ff[rd_lv] == tgt_ff) begin
                  head_in[rd_lv] = nxt_rdata;
               end else begin
                  nxt_we    = 1'b1;
                  nxt_waddr = rd_pv;
                  nxt_wdata = nxt_rdata;
               end
               if (tail_ff[rd_lv] == tgt_ff) begin
                  tail_in[rd_lv] = rd_pv;
               end else begin
                  aux_we    = 1'b1;
                  aux_waddr = nxt_rdata;
                  aux_wdata = {1'b1, rd_lv, rd_pv};
               end
               if (count_ff[rd_lv] != '0) count_in[rd_lv] = count_ff[rd_lv] - 1'b1;
               if (total_ff != '0) total_in = total_ff - 1'b1;
            end
         end
         S_UNLINK_B: begin
            aux_we    = 1'b1;
            aux_waddr = tgt_ff;
            aux_wdata = '0;
            status_in = ST_OK;
            picked_in = 6'(tgt_ff);
            if (cmd_ff.operation == OP_SCHEDULE) begin
               running_in = tgt_ff;
               if (!cmd_ff.outgoing_ended && !pr_ok) status_in = ST_BAD_PRIO;
            end
         end
         S_OUT_RD: begin
            aux_re    = 1'b1;
            aux_raddr = out_ff;
         end
         S_OUT_CHK: begin
            if (rd_q) begin
               status_in = ST_QUEUED;
            end else begin
               push_en   = 1'b1;
               push_task = out_ff;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.status      = status_ff;
               rsp_data_in.picked_task = picked_ff;
               rsp_data_in.ready_total = 7'(total_ff);
            end
         end
         default: begin
            clr_in = '0;
         end
      endcase

      if (push_en) begin
         if (count_ff[pr_idx] == '0) begin
            head_in[pr_idx] = push_task;
         end else begin
            nxt_we    = 1'b1;
            nxt_waddr = tail_ff[pr_idx];
            nxt_wdata = push_task;
         end
         aux_we          = 1'b1;
         aux_waddr       = push_task;
         aux_wdata       = {1'b1, pr_idx, tail_ff[pr_idx]};
         tail_in[pr_idx] = push_task;
         count_in[pr_idx] = count_ff[pr_idx] + 1'b1;
         total_in        = total_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         running_ff   <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int lv = 0; lv < LEVELS; lv++) begin
            head_ff[lv]  <= '0;
            tail_ff[lv]  <= '0;
            count_ff[lv] <= '0;
            quota_ff[lv] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         running_ff   <= running_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         quota_ff     <= quota_in;
      end
      cmd_ff      <= cmd_in;
      tgt_ff      <= tgt_in;
      out_ff      <= out_in;
      status_ff   <= status_in;
      picked_ff   <= picked_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      32'(total_ff) <= TASKS)
      else $error("ready total exceeds the task count");

   a_done_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_free) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("finished request did not reach the response register");

   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> (req_stall && !nxt_we))
      else $error("request or link write during the clearing pass");

   a_running_switch: assert property (@(posedge clock) disable iff (reset)
      !$stable(running_ff) |-> ($past(state_ff) == S_UNLINK_B
                                && $past(cmd_ff.operation) == OP_SCHEDULE))
      else $error("running task changed outside a schedule");

   a_push_single: assert property (@(posedge clock) disable iff (reset)
      push_en |-> (state_ff == S_ENQ || state_ff == S_OUT_CHK))
      else $error("queue append outside an append step");

endmodule
